// File: hw/rtl/gbnsw_pkg.sv
// ----------------------------------------------------------------------------
// gbnsw_pkg: Go-Back-N sender window shared types
// Event and result beat layouts, event kinds, register indexes and the
// wrapped sequence helpers.
// ----------------------------------------------------------------------------
package gbnsw_pkg;

	localparam int SEQ_W       = 8;   // sequence numbers and window size
	localparam int FIELD_IDX_W = 16;  // frame index fields of a result beat
	localparam int FCOUNT_W    = 16;  // frame_count register
	localparam int KIND_W      = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [KIND_W-1:0] KIND_START   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DONE    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ACK     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NACK    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd1;

	localparam logic [SEQ_W-1:0] WINDOW_RESET = 8'd4;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SEQ_W-1:0]  ack_num;
	} evt_t;

	typedef struct packed {
		logic                   send_frame;
		logic [FIELD_IDX_W-1:0] send_index;
		logic [SEQ_W-1:0]       send_seq;
		logic                   arm_timer;
		logic                   cancel_oldest_timer;
		logic                   cancel_all_timers;
		logic [SEQ_W-1:0]       timeout_seq;
		logic                   cancel_processing;
		logic                   start_processing;
		logic [FIELD_IDX_W-1:0] start_index;
		logic                   all_sent;
	} rslt_t;

	// Sequence modulus M = window + 1, a zero window counts as one.
	function automatic logic [SEQ_W:0] seq_modulus(logic [SEQ_W-1:0] ws);
		logic [SEQ_W-1:0] eff;
		eff = (ws == '0) ? SEQ_W'(1) : ws;
		return {1'b0, eff} + (SEQ_W+1)'(1);
	endfunction

	function automatic logic [SEQ_W-1:0] seq_inc(logic [SEQ_W-1:0] s, logic [SEQ_W:0] m);
		logic [SEQ_W:0] t;
		t = {1'b0, s} + (SEQ_W+1)'(1);
		return (t >= m) ? '0 : t[SEQ_W-1:0];
	endfunction

endpackage

// File: hw/rtl/go_back_n_sender_window.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_window: Go-Back-N ARQ sender window controller
// Takes one event beat (start, done, timeout, ack, nack) and returns one
// command beat: send/arm, cancel timers, cancel or start processing.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | dir | beat
//  --------+----------------------------------+-----+-------------------------
//  evt     | evt_valid, evt_ready, evt        | in  | kind, ack_num
//  rslt    | rslt_valid, rslt_ready, rslt     | out | command flags and fields
//  cfg     | cfg_valid, cfg_ready, cfg_index, | in  | 0 window (data[7:0])
//          | cfg_data                         |     | 1 frame_count
//
//  Flow: one event beat per cycle while no window write is being worked and
//  the result register is free or drained. The window update runs between
//  the input register and the result register; an event waits in the input
//  register while the result is held. A window write recomputes the wrapped
//  sequence counters by a bit-serial remainder over the indices, with
//  evt_ready and cfg_ready low. Reset: window 4, frame_count 0, empty window.
// ----------------------------------------------------------------------------
module go_back_n_sender_window #(
	parameter int INDEX_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                evt_valid,
	output logic                                evt_ready,
	input  gbnsw_pkg::evt_t                     evt,
	output logic                                rslt_valid,
	input  logic                                rslt_ready,
	output gbnsw_pkg::rslt_t                    rslt,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gbnsw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gbnsw_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int SW    = gbnsw_pkg::SEQ_W;
	localparam int FW    = gbnsw_pkg::FIELD_IDX_W;
	localparam int CW    = (INDEX_WIDTH > gbnsw_pkg::FCOUNT_W) ? INDEX_WIDTH
	                                                          : gbnsw_pkg::FCOUNT_W;
	localparam int CNT_W = $clog2(INDEX_WIDTH + 1);
	localparam int BIT_W = $clog2(INDEX_WIDTH);
	localparam int LANES = 3;  // base, next, processing

	// configuration
	logic [SW-1:0]                        window_q;
	logic [gbnsw_pkg::FCOUNT_W-1:0]       frame_count_q;
	logic [SW:0]                          seq_mod;

	// window state
	logic [INDEX_WIDTH-1:0] base_index_q, end_index_q, next_index_q, proc_index_q;
	logic [SW-1:0]          base_seq_q, next_seq_q, proc_seq_q;
	logic                   busy_q;

	// next-state from the event in the input register
	logic [INDEX_WIDTH-1:0] base_index_d, end_index_d, next_index_d, proc_index_d;
	logic [SW-1:0]          base_seq_d, next_seq_d, proc_seq_d;
	logic                   busy_d;

	// input and result registers
	gbnsw_pkg::evt_t  evt_s1;
	logic             evt_valid_s1;
	gbnsw_pkg::rslt_t rslt_d, rslt_q;
	logic             rslt_valid_q;

	// bit-serial remainder lanes
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_dec;
	logic [BIT_W-1:0] bit_idx;
	logic [SW-1:0]    rem_q [LANES];
	logic [SW-1:0]    rem_d [LANES];
	logic [LANES-1:0] lane_bit;
	logic             rem_busy;

	logic evt_acc, cfg_acc, advance;

	assign seq_mod  = gbnsw_pkg::seq_modulus(window_q);
	assign rem_busy = (cnt_q != '0);

	// an event taken together with a window write waits for the remainder unit
	assign advance   = evt_valid_s1 && !rem_busy && (!rslt_valid_q || rslt_ready);
	assign evt_ready = !rem_busy && (!evt_valid_s1 || advance);
	assign cfg_ready = !rem_busy && !evt_valid_s1;
	assign evt_acc   = evt_valid && evt_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;

	assign rslt_valid = rslt_valid_q;
	assign rslt       = rslt_q;

	// ------------------------------------------------------------------
	// Remainder unit: index mod M, MSB first, one bit per cycle per lane.
	// The remainder stays below M <= 256, so it fits SW bits.
	// ------------------------------------------------------------------
	assign cnt_dec = cnt_q - CNT_W'(1);
	assign bit_idx = cnt_dec[BIT_W-1:0];

	always_comb begin
		lane_bit[0] = base_index_q[bit_idx];
		lane_bit[1] = next_index_q[bit_idx];
		lane_bit[2] = proc_index_q[bit_idx];
	end

	always_comb begin
		logic [SW:0] sh;
		for (int i = 0; i < LANES; i++) begin
			sh = {rem_q[i], lane_bit[i]};
			if (sh >= seq_mod) begin
				sh = sh - seq_mod;
			end
			rem_d[i] = sh[SW-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Event step
	// ------------------------------------------------------------------
	always_comb begin
		logic                   tail;
		logic [CW-1:0]          fc_m1;
		logic [INDEX_WIDTH-1:0] last_index;
		logic [CW-1:0]          idx_ext;
		logic [CW-1:0]          fc_ext;
		logic [SW-1:0]          base_inc;

		rslt_d       = '0;
		tail         = 1'b0;
		base_index_d = base_index_q;
		end_index_d  = end_index_q;
		next_index_d = next_index_q;
		proc_index_d = proc_index_q;
		base_seq_d   = base_seq_q;
		next_seq_d   = next_seq_q;
		proc_seq_d   = proc_seq_q;
		busy_d       = busy_q;
		fc_ext       = CW'(frame_count_q);
		fc_m1        = fc_ext - CW'(1);
		last_index   = fc_m1[INDEX_WIDTH-1:0];
		base_inc     = gbnsw_pkg::seq_inc(base_seq_q, seq_mod);
		idx_ext      = CW'(proc_index_q);

		unique case (evt_s1.kind)
			gbnsw_pkg::KIND_START: begin
				tail = 1'b1;
			end
			gbnsw_pkg::KIND_DONE: begin
				if (busy_q) begin
					rslt_d.send_frame = 1'b1;
					rslt_d.send_index = idx_ext[FW-1:0];
					rslt_d.send_seq   = proc_seq_q;
					rslt_d.arm_timer  = 1'b1;
					busy_d            = 1'b0;
				end
				tail = 1'b1;
			end
			gbnsw_pkg::KIND_TIMEOUT: begin
				rslt_d.timeout_seq       = base_seq_q;
				rslt_d.cancel_all_timers = 1'b1;
				rslt_d.cancel_processing = busy_q;
				next_index_d             = base_index_q;
				next_seq_d               = base_seq_q;
				busy_d                   = 1'b0;
				tail                     = 1'b1;
			end
			gbnsw_pkg::KIND_ACK: begin
				// only the ack right after the base, with a frame issued past it
				if (evt_s1.ack_num == base_inc && next_index_q != base_index_q) begin
					base_index_d = base_index_q + INDEX_WIDTH'(1);
					base_seq_d   = base_inc;
					if (end_index_q != last_index) begin
						end_index_d = end_index_q + INDEX_WIDTH'(1);
					end
					rslt_d.cancel_oldest_timer = 1'b1;
					tail                       = 1'b1;
				end
			end
			gbnsw_pkg::KIND_NACK: begin
				// nack for the base rewinds like a timeout, without timeout_seq
				if (evt_s1.ack_num == base_seq_q) begin
					rslt_d.cancel_all_timers = 1'b1;
					rslt_d.cancel_processing = busy_q;
					next_index_d             = base_index_q;
					next_seq_d               = base_seq_q;
					busy_d                   = 1'b0;
					tail                     = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// issue the next frame into processing when idle and inside the window
		if (tail && !busy_d && next_index_d <= end_index_d &&
		    CW'(next_index_d) < fc_ext) begin
			idx_ext                 = CW'(next_index_d);
			rslt_d.start_processing = 1'b1;
			rslt_d.start_index      = idx_ext[FW-1:0];
			proc_index_d            = next_index_d;
			proc_seq_d              = next_seq_d;
			busy_d                  = 1'b1;
			next_index_d            = next_index_d + INDEX_WIDTH'(1);
			next_seq_d              = gbnsw_pkg::seq_inc(next_seq_d, seq_mod);
		end

		rslt_d.all_sent = (CW'(next_index_d) >= fc_ext);
	end

	// ------------------------------------------------------------------
	// Control and state registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q      <= gbnsw_pkg::WINDOW_RESET;
			frame_count_q <= '0;
			base_index_q  <= '0;
			end_index_q   <= INDEX_WIDTH'(gbnsw_pkg::WINDOW_RESET - SW'(1));
			next_index_q  <= '0;
			proc_index_q  <= '0;
			base_seq_q    <= '0;
			next_seq_q    <= '0;
			proc_seq_q    <= '0;
			busy_q        <= 1'b0;
			cnt_q         <= '0;
			for (int i = 0; i < LANES; i++) begin
				rem_q[i] <= '0;
			end
		end else if (cfg_acc) begin
			if (cfg_index == gbnsw_pkg::REG_WINDOW_SIZE) begin
				logic [SW:0] m_new;
				m_new = gbnsw_pkg::seq_modulus(cfg_data[SW-1:0]);
				window_q    <= cfg_data[SW-1:0];
				end_index_q <= base_index_q + INDEX_WIDTH'(m_new - (SW+1)'(1))
				               - INDEX_WIDTH'(1);
				cnt_q       <= CNT_W'(INDEX_WIDTH);
				for (int i = 0; i < LANES; i++) begin
					rem_q[i] <= '0;
				end
			end else if (cfg_index == gbnsw_pkg::REG_FRAME_COUNT) begin
				frame_count_q <= cfg_data;
			end
		end else if (rem_busy) begin
			cnt_q <= cnt_dec;
			for (int i = 0; i < LANES; i++) begin
				rem_q[i] <= rem_d[i];
			end
			if (cnt_q == CNT_W'(1)) begin
				base_seq_q <= rem_d[0];
				next_seq_q <= rem_d[1];
				proc_seq_q <= rem_d[2];
			end
		end else if (advance) begin
			base_index_q <= base_index_d;
			end_index_q  <= end_index_d;
			next_index_q <= next_index_d;
			proc_index_q <= proc_index_d;
			base_seq_q   <= base_seq_d;
			next_seq_q   <= next_seq_d;
			proc_seq_q   <= proc_seq_d;
			busy_q       <= busy_d;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s1 <= 1'b0;
		end else if (evt_acc) begin
			evt_valid_s1 <= 1'b1;
		end else if (advance) begin
			evt_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_acc) begin
			evt_s1 <= evt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rslt_valid_q <= 1'b0;
		end else if (advance) begin
			rslt_valid_q <= 1'b1;
		end else if (rslt_ready) begin
			rslt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rslt_q <= rslt_d;
		end
	end

endmodule
